[src/u8vd_pkg.sv]
// Package for the UTF-8 validating decoder.
// Holds the word types, status codes and decode constants shared by all modules.
// Depends on nothing.
package u8vd_pkg;

	localparam int MAX_CODEPOINTS = 64;
	localparam int CNT_W = $clog2(MAX_CODEPOINTS + 1);
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [20:0] CP_MAX = 21'h10FFFF;
	localparam logic [20:0] SURR_LO = 21'h00D800;
	localparam logic [20:0] SURR_HI = 21'h00DFFF;
	localparam logic [20:0] MIN_CP [4] = '{21'h0, 21'h80, 21'h800, 21'h10000};

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_BAD_LEAD = 3'd1,
		ST_BAD_CONT = 3'd2,
		ST_INVALID = 3'd3,
		ST_TOO_MANY = 3'd4,
		ST_TRUNCATED = 3'd5
	} status_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       last_byte;
	} text_t;

	typedef struct packed {
		logic [20:0] codepoint;
		status_t     status;
		logic [6:0]  cp_count;
		logic        end_of_text;
	} result_t;

	// A byte classified both as a possible lead and as a possible continuation.
	typedef struct packed {
		logic       lead_ok;
		logic [1:0] lead_len;
		logic [6:0] lead_bits;
		logic       cont_ok;
		logic [5:0] cont_bits;
		logic       last;
	} class_t;

	typedef struct packed {
		logic [1:0]       pend;
		logic [1:0]       cls;
		logic [20:0]      part;
		logic [CNT_W-1:0] count;
		logic             disc;
	} bk_state_t;

endpackage

[src/u8vd_front.sv]
// Front end of the UTF-8 validating decoder: input handshake and byte classification.
// Depends on u8vd_pkg.
module u8vd_front import u8vd_pkg::*; (
	input  logic   text_valid,
	output logic   text_ready,
	input  text_t  text,
	input  logic   q_full,
	output logic   q_push,
	output class_t q_item
);

	always_comb begin
		q_item = '0;
		q_item.last = text.last_byte;
		q_item.cont_ok = (text.text_byte[7:6] == 2'b10);
		q_item.cont_bits = text.text_byte[5:0];
		if (text.text_byte[7] == 1'b0) begin
			q_item.lead_ok = 1'b1;
			q_item.lead_len = 2'd0;
			q_item.lead_bits = text.text_byte[6:0];
		end else if (text.text_byte[7:5] == 3'b110) begin
			q_item.lead_ok = 1'b1;
			q_item.lead_len = 2'd1;
			q_item.lead_bits = {2'b00, text.text_byte[4:0]};
		end else if (text.text_byte[7:4] == 4'b1110) begin
			q_item.lead_ok = 1'b1;
			q_item.lead_len = 2'd2;
			q_item.lead_bits = {3'b000, text.text_byte[3:0]};
		end else if (text.text_byte[7:3] == 5'b11110) begin
			q_item.lead_ok = 1'b1;
			q_item.lead_len = 2'd3;
			q_item.lead_bits = {4'b0000, text.text_byte[2:0]};
		end
	end

	assign text_ready = !q_full;
	assign q_push = text_valid && !q_full;

endmodule

[src/u8vd_queue.sv]
// Short queue that decouples the classifier from the decode back end.
// Depends on u8vd_pkg.
module u8vd_queue import u8vd_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  class_t push_item,
	input  logic   pop,
	output logic   full,
	output logic   not_empty,
	output class_t head
);

	class_t            mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_pop;

	assign full = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign not_empty = (cnt_q != '0);
	assign do_pop = pop && not_empty;
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(wr_ptr_q + 1'b1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(rd_ptr_q + 1'b1);
			end
			if (push && !do_pop) begin
				cnt_q <= QCNT_W'(cnt_q + 1'b1);
			end else if (do_pop && !push) begin
				cnt_q <= QCNT_W'(cnt_q - 1'b1);
			end
		end
	end

endmodule

[src/u8vd_back.sv]
// Back end of the UTF-8 validating decoder: sequence assembly, validation, counting
// and the registered result word. Depends on u8vd_pkg.
module u8vd_back import u8vd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    q_not_empty,
	input  class_t  q_head,
	output logic    q_pop,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	bk_state_t st_q;
	bk_state_t st_nxt;
	result_t   res_q;
	result_t   res_nxt;
	logic      res_valid_q;
	logic      emit;
	logic      err;
	status_t   err_code;
	logic [20:0] cp;

	assign q_pop = q_not_empty && (!res_valid_q || result_ready);

	always_comb begin
		st_nxt = st_q;
		res_nxt = '0;
		emit = 1'b0;
		err = 1'b0;
		err_code = ST_OK;
		cp = st_q.part;
		if (st_q.disc) begin
			if (q_head.last) begin
				st_nxt = '0;
			end
		end else begin
			if (st_q.pend == 2'd0) begin
				if (!q_head.lead_ok) begin
					err = 1'b1;
					err_code = ST_BAD_LEAD;
				end else begin
					st_nxt.part = 21'(q_head.lead_bits);
					st_nxt.cls = q_head.lead_len;
					st_nxt.pend = q_head.lead_len;
				end
			end else if (!q_head.cont_ok) begin
				err = 1'b1;
				err_code = ST_BAD_CONT;
			end else begin
				st_nxt.part = {st_q.part[14:0], q_head.cont_bits};
				st_nxt.pend = st_q.pend - 2'd1;
			end
			cp = st_nxt.part;
			if (!err) begin
				if (st_nxt.pend != 2'd0) begin
					if (q_head.last) begin
						err = 1'b1;
						err_code = ST_TRUNCATED;
					end
				end else if (cp < MIN_CP[st_nxt.cls] || cp > CP_MAX
						|| (cp >= SURR_LO && cp <= SURR_HI)) begin
					err = 1'b1;
					err_code = ST_INVALID;
				end else if (st_q.count >= CNT_W'(MAX_CODEPOINTS)) begin
					err = 1'b1;
					err_code = ST_TOO_MANY;
				end else begin
					emit = 1'b1;
					res_nxt.codepoint = cp;
					res_nxt.status = ST_OK;
					res_nxt.cp_count = 7'(CNT_W'(st_q.count + 1'b1));
					res_nxt.end_of_text = q_head.last;
					st_nxt.count = CNT_W'(st_q.count + 1'b1);
					st_nxt.part = '0;
					st_nxt.cls = '0;
					if (q_head.last) begin
						st_nxt = '0;
					end
				end
			end
			if (err) begin
				emit = 1'b1;
				res_nxt.codepoint = '0;
				res_nxt.status = err_code;
				res_nxt.cp_count = 7'(st_q.count);
				res_nxt.end_of_text = 1'b1;
				st_nxt.pend = '0;
				st_nxt.cls = '0;
				st_nxt.part = '0;
				st_nxt.disc = 1'b1;
				if (q_head.last) begin
					st_nxt = '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				st_q <= st_nxt;
				res_valid_q <= emit;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && emit) begin
			res_q <= res_nxt;
		end
	end

	assign result_valid = res_valid_q;
	assign result = res_q;

`ifndef SYNTHESIS
	a_err_ends_text: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status != ST_OK |-> result.end_of_text && result.codepoint == '0)
		else $error("error word without end of text or with a codepoint");
	a_ok_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status == ST_OK |-> result.codepoint <= CP_MAX)
		else $error("accepted codepoint out of range");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.count <= CNT_W'(MAX_CODEPOINTS))
		else $error("codepoint count above limit");
	a_disc_idle: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.disc |-> st_q.pend == 2'd0 && st_q.part == '0)
		else $error("pending sequence while discarding");
	a_pop_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop && emit |=> result_valid)
		else $error("result word lost after pop");
`endif

endmodule

[src/utf8_validating_decoder.sv]
// Top level of the UTF-8 validating decoder.
// Instantiates u8vd_front, u8vd_queue and u8vd_back; depends on u8vd_pkg.

// Decodes one UTF-8 byte per word into Unicode scalars, one result word per
// completed scalar and one error word (end_of_text set) for any fault, after which
// bytes are dropped through the next word flagged last. The block sustains one byte
// per cycle while result words are taken: the back end updates its sequence state
// once per byte. An accepted byte is written into the queue, and when the back end
// pops it, any result word it causes is registered in the result register and
// offered from there. A two-word queue sits between the classifier and the back end,
// and the result sits in its own register. While a result waits, the queue takes
// up to two more bytes before the input stalls.
module utf8_validating_decoder import u8vd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    text_valid,
	output logic    text_ready,
	input  text_t   text,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	logic   q_full;
	logic   q_push;
	logic   q_pop;
	logic   q_not_empty;
	class_t q_in;
	class_t q_head;

	u8vd_front u_front (
		.text_valid (text_valid),
		.text_ready (text_ready),
		.text       (text),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_item     (q_in)
	);

	u8vd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_in),
		.pop       (q_pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	u8vd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_not_empty  (q_not_empty),
		.q_head       (q_head),
		.q_pop        (q_pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// Testbench for utf8_validating_decoder: random UTF-8 strings and faults, checked by a scalar ledger.
// Depends on u8vd_pkg and the decoder RTL only.
module tb;
	import u8vd_pkg::*;

	localparam int ITEM_TARGET = 900;
	localparam int CALM_AFTER = 720;
	localparam int CYCLE_LIMIT = 400000;

	localparam logic [8:0] OPENING_BYTES [26] = '{
		{8'h41, 1'b1},
		{8'h00, 1'b0}, {8'h7F, 1'b1},
		{8'hC3, 1'b0}, {8'hA9, 1'b0}, {8'hE2, 1'b0}, {8'h82, 1'b0}, {8'hAC, 1'b0},
		{8'hF4, 1'b0}, {8'h8F, 1'b0}, {8'hBF, 1'b0}, {8'hBF, 1'b1},
		{8'h80, 1'b0}, {8'h41, 1'b0}, {8'h42, 1'b1},
		{8'hC3, 1'b0}, {8'h00, 1'b1},
		{8'hC0, 1'b0}, {8'h80, 1'b1},
		{8'hED, 1'b0}, {8'hA0, 1'b0}, {8'h80, 1'b1},
		{8'hE2, 1'b0}, {8'h82, 1'b1},
		{8'hC3, 1'b1},
		{8'hFF, 1'b1}
	};

	class scalar_ledger;
		logic [1:0]  pend;
		logic [1:0]  seq_cls;
		logic [20:0] part;
		int          accepted;
		bit          skipping;
		result_t     awaited_scalars [$];
		int          errors;

		function new();
			restart();
			errors = 0;
		endfunction

		function void restart();
			pend = '0;
			seq_cls = '0;
			part = '0;
			accepted = 0;
			skipping = 1'b0;
		endfunction

		function void add_result(logic [20:0] cp, status_t st, logic eot);
			result_t r;
			r.codepoint = cp;
			r.status = st;
			r.cp_count = 7'(accepted);
			r.end_of_text = eot;
			awaited_scalars.push_back(r);
		endfunction

		function void raise_fault(status_t st, logic lst);
			add_result('0, st, 1'b1);
			if (lst) begin
				restart();
			end else begin
				pend = '0;
				seq_cls = '0;
				part = '0;
				skipping = 1'b1;
			end
		endfunction

		function void note_byte(text_t w);
			logic [7:0] c;
			logic       lst;
			c = w.text_byte;
			lst = w.last_byte;
			if (skipping) begin
				if (lst)
					restart();
				return;
			end
			if (pend == 2'd0) begin
				if (!c[7]) begin
					part = {13'd0, c};
					seq_cls = 2'd0;
				end else if (c[7:5] == 3'b110) begin
					part = {16'd0, c[4:0]};
					seq_cls = 2'd1;
				end else if (c[7:4] == 4'b1110) begin
					part = {17'd0, c[3:0]};
					seq_cls = 2'd2;
				end else if (c[7:3] == 5'b11110) begin
					part = {18'd0, c[2:0]};
					seq_cls = 2'd3;
				end else begin
					raise_fault(ST_BAD_LEAD, lst);
					return;
				end
				pend = seq_cls;
			end else begin
				if (c[7:6] != 2'b10) begin
					raise_fault(ST_BAD_CONT, lst);
					return;
				end
				part = {part[14:0], c[5:0]};
				pend = pend - 2'd1;
			end
			if (pend != 2'd0) begin
				if (lst)
					raise_fault(ST_TRUNCATED, lst);
				return;
			end
			if (part < MIN_CP[seq_cls] || part > CP_MAX || (part >= SURR_LO && part <= SURR_HI)) begin
				raise_fault(ST_INVALID, lst);
				return;
			end
			if (accepted >= MAX_CODEPOINTS) begin
				raise_fault(ST_TOO_MANY, lst);
				return;
			end
			accepted++;
			add_result(part, ST_OK, lst);
			part = '0;
			seq_cls = '0;
			if (lst)
				restart();
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (awaited_scalars.size() == 0) begin
				$error("unexpected result word: codepoint %h status %0d", got.codepoint, got.status);
				errors++;
				return;
			end
			want = awaited_scalars.pop_front();
			if (got.codepoint !== want.codepoint) begin
				$error("codepoint: expected %h, got %h", want.codepoint, got.codepoint);
				errors++;
			end
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				errors++;
			end
			if (got.cp_count !== want.cp_count) begin
				$error("cp_count: expected %0d, got %0d", want.cp_count, got.cp_count);
				errors++;
			end
			if (got.end_of_text !== want.end_of_text) begin
				$error("end_of_text: expected %0d, got %0d", want.end_of_text, got.end_of_text);
				errors++;
			end
		endfunction
	endclass

	logic    clk = 1'b0;
	logic    arst_n;
	logic    text_valid;
	logic    text_ready;
	text_t   text;
	logic    result_valid;
	logic    result_ready;
	result_t result;

	scalar_ledger ledger;
	logic [7:0]   line_bytes [$];
	bit           bursts_on = 1'b1;
	int           stall_left = 0;
	int           items_sent = 0;
	int           cycle_count = 0;

	utf8_validating_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.text_valid(text_valid),
		.text_ready(text_ready),
		.text(text),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (bursts_on && stall_left == 0 && $urandom_range(0, 5) == 0)
			stall_left = $urandom_range(1, 5);
		if (stall_left > 0) begin
			result_ready <= 1'b0;
			stall_left--;
		end else begin
			result_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (text_valid && text_ready)
				ledger.note_byte(text);
			if (result_valid && result_ready)
				ledger.check_result(result);
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	function automatic logic [20:0] random_scalar(int k);
		logic [20:0] v;
		case (k)
			0: v = 21'($urandom_range(0, 'h7F));
			1: v = 21'($urandom_range('h80, 'h7FF));
			2: begin
				v = 21'($urandom_range('h800, 'hF7FF));
				if (v >= SURR_LO)
					v = v + 21'h800;
			end
			default: v = 21'($urandom_range('h10000, 'h10FFFF));
		endcase
		return v;
	endfunction

	function automatic void push_scalar(logic [20:0] v, int k);
		case (k)
			0: line_bytes.push_back({1'b0, v[6:0]});
			1: begin
				line_bytes.push_back({3'b110, v[10:6]});
				line_bytes.push_back({2'b10, v[5:0]});
			end
			2: begin
				line_bytes.push_back({4'b1110, v[15:12]});
				line_bytes.push_back({2'b10, v[11:6]});
				line_bytes.push_back({2'b10, v[5:0]});
			end
			default: begin
				line_bytes.push_back({5'b11110, v[20:18]});
				line_bytes.push_back({2'b10, v[17:12]});
				line_bytes.push_back({2'b10, v[11:6]});
				line_bytes.push_back({2'b10, v[5:0]});
			end
		endcase
	endfunction

	function automatic void push_fault();
		int         k;
		int         j;
		logic [7:0] b;
		k = $urandom_range(1, 3);
		case ($urandom_range(0, 5))
			0: push_scalar(21'($urandom_range(0, int'(MIN_CP[k]) - 1)), k);
			1: push_scalar(21'($urandom_range('hD800, 'hDFFF)), 2);
			2: push_scalar(21'($urandom_range('h110000, 'h1FFFFF)), 3);
			3: begin
				if ($urandom_range(0, 1))
					line_bytes.push_back(8'($urandom_range('h80, 'hBF)));
				else
					line_bytes.push_back(8'($urandom_range('hF8, 'hFF)));
			end
			4: begin
				push_scalar(random_scalar(k), k);
				b = 8'($urandom_range(0, 255));
				if (b[7:6] == 2'b10)
					b[6] = 1'b1;
				j = line_bytes.size() - int'($urandom_range(1, k));
				line_bytes[j] = b;
			end
			default: begin
				push_scalar(random_scalar(k), k);
				repeat ($urandom_range(1, k))
					void'(line_bytes.pop_back());
			end
		endcase
	endfunction

	function automatic void build_line(int idx);
		int  n;
		int  fault_at;
		int  k;
		bit  long_line;
		line_bytes.delete();
		if ($urandom_range(0, 19) == 0) begin
			repeat ($urandom_range(1, 10))
				line_bytes.push_back(8'($urandom_range(0, 255)));
			return;
		end
		long_line = (idx % 30 == 2);
		n = long_line ? $urandom_range(63, 66) : $urandom_range(1, 8);
		fault_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n - 1) : -1;
		for (int i = 0; i < n; i++) begin
			if (i == fault_at) begin
				push_fault();
			end else if (long_line && $urandom_range(0, 3) != 0) begin
				push_scalar(random_scalar(0), 0);
			end else begin
				k = (i % 4 == 0) ? 0 : int'($urandom_range(0, 3));
				push_scalar(random_scalar(k), k);
			end
		end
	endfunction

	task automatic send_word(input logic [7:0] b, input logic lst);
		text_t w;
		w.text_byte = b;
		w.last_byte = lst;
		if (bursts_on && $urandom_range(0, 4) == 0) begin
			text_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		text <= w;
		text_valid <= 1'b1;
		do @(posedge clk); while (!text_ready);
		items_sent++;
	endtask

	task automatic send_line();
		for (int i = 0; i < line_bytes.size(); i++)
			send_word(line_bytes[i], i == line_bytes.size() - 1);
	endtask

	task automatic wait_for_drain();
		text_valid <= 1'b0;
		do @(posedge clk); while (ledger.awaited_scalars.size() != 0);
	endtask

	initial begin
		int line_idx;
		ledger = new();
		arst_n <= 1'b0;
		text_valid <= 1'b0;
		text <= '0;
		result_ready <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (OPENING_BYTES[i])
			send_word(OPENING_BYTES[i][8:1], OPENING_BYTES[i][0]);
		line_idx = 0;
		while (items_sent < ITEM_TARGET) begin
			if (items_sent > CALM_AFTER)
				bursts_on = 1'b0;
			build_line(line_idx);
			send_line();
			if (line_idx % 20 == 4)
				wait_for_drain();
			line_idx++;
		end
		wait_for_drain();
		repeat (8) @(posedge clk);
		if (ledger.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule

[files.f]
src/u8vd_pkg.sv
src/u8vd_front.sv
src/u8vd_queue.sv
src/u8vd_back.sv
src/utf8_validating_decoder.sv
tb/sv/tb.sv
